[sv/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, codes and defaults of the delayed task queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF  = 32;

  localparam int unsigned HANDLE_W    = 16;
  localparam int unsigned DELAY_W     = 20;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned DISP_CNT_W  = $clog2(MAX_RESULTS + 1);

  // item kinds
  localparam logic [1:0] KIND_POST = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DISPATCH = 2'd0;
  localparam logic [1:0] ST_ACCEPT   = 2'd1;
  localparam logic [1:0] ST_REFUSE   = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] task_handle;
    logic [DELAY_W-1:0]  delay_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] task_handle_out;
    logic                last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } result_evt_t;

endpackage

[sv/dtq_ram.sv]
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/dtq_seq.sv]
// ----------------------------------------------------------------------------
// dtq_seq
// Sequencer of the delayed task queue: ring pointers, time counter, insert
// walk and dispatch walk over the entry RAM.
// ----------------------------------------------------------------------------
module dtq_seq #(
  parameter int unsigned QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH  = dtq_pkg::TIME_WIDTH_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             start_i,
  input  dtq_pkg::item_t                                   item_i,
  output logic                                             busy_o,
  output dtq_pkg::result_evt_t                             evt_o,
  output logic                                             ram_we_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]                   ram_waddr_o,
  output logic [TIME_WIDTH+dtq_pkg::HANDLE_W-1:0]          ram_wdata_o,
  output logic                                             ram_re_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0]                   ram_raddr_o,
  input  logic [TIME_WIDTH+dtq_pkg::HANDLE_W-1:0]          ram_rdata_i
);

  import dtq_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W = TIME_WIDTH + HANDLE_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_POST     = 3'd1;
  localparam logic [2:0] S_TICK_RD  = 3'd2;
  localparam logic [2:0] S_TICK_EV  = 3'd3;
  localparam logic [2:0] S_TICK_END = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [TIME_WIDTH-1:0] now_q, now_d;
  logic                  stopped_q, stopped_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  rd_pend_q, rd_pend_d;
  logic                  found_q, found_d;
  logic [DISP_CNT_W-1:0] n_q, n_d;
  logic                  pend_q, pend_d;

  logic [TIME_WIDTH-1:0] new_due_q, new_due_d;
  logic [HANDLE_W-1:0]   new_handle_q, new_handle_d;
  logic [ENT_W-1:0]      carry_q, carry_d;
  logic [HANDLE_W-1:0]   pend_handle_q, pend_handle_d;

  logic [TIME_WIDTH-1:0] rd_due;
  logic [HANDLE_W-1:0]   rd_handle;
  logic [TIME_WIDTH-1:0] later_diff;
  logic                  rd_later;
  logic [TIME_WIDTH-1:0] age;
  logic [ENT_W-1:0]      new_entry;
  logic [CNT_W-1:0]      prev_idx;

  // map a position counted from the head onto a RAM address
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = (IDX_W+1)'(head) + (IDX_W+1)'(pos);
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign rd_due     = ram_rdata_i[ENT_W-1:HANDLE_W];
  assign rd_handle  = ram_rdata_i[HANDLE_W-1:0];
  assign later_diff = rd_due - new_due_q;
  assign rd_later   = (later_diff != '0) && !later_diff[TIME_WIDTH-1];
  assign age        = now_q - rd_due;
  assign new_entry  = {new_due_q, new_handle_q};
  assign prev_idx   = idx_q - CNT_W'(1);

  always_comb begin
    state_d       = state_q;
    head_d        = head_q;
    count_d       = count_q;
    now_d         = now_q;
    stopped_d     = stopped_q;
    idx_d         = idx_q;
    rd_pend_d     = rd_pend_q;
    found_d       = found_q;
    n_d           = n_q;
    pend_d        = pend_q;
    new_due_d     = new_due_q;
    new_handle_d  = new_handle_q;
    carry_d       = carry_q;
    pend_handle_d = pend_handle_q;

    evt_o                     = '0;
    ram_we_o                  = 1'b0;
    ram_waddr_o               = '0;
    ram_wdata_o               = new_entry;
    ram_re_o                  = 1'b0;
    ram_raddr_o               = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (item_i.kind)
            KIND_POST: begin
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                evt_o.valid               = 1'b1;
                evt_o.res.status          = ST_REFUSE;
                evt_o.res.task_handle_out = item_i.task_handle;
                evt_o.res.last            = 1'b1;
              end else begin
                new_due_d    = now_q + TIME_WIDTH'(item_i.delay_ms);
                new_handle_d = item_i.task_handle;
                idx_d        = '0;
                rd_pend_d    = 1'b0;
                found_d      = 1'b0;
                state_d      = S_POST;
              end
            end
            KIND_TICK: begin
              now_d = now_q + TIME_WIDTH'(1);
              if (!stopped_q) begin
                n_d     = '0;
                pend_d  = 1'b0;
                state_d = S_TICK_RD;
              end
            end
            KIND_STOP: begin
              stopped_d = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_POST: begin
        // evaluate the entry read last cycle, rippling the tail up by one
        if (rd_pend_q) begin
          if (found_q) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = phys(head_q, prev_idx);
            ram_wdata_o = carry_q;
            carry_d     = ram_rdata_i;
          end else if (rd_later) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = phys(head_q, prev_idx);
            ram_wdata_o = new_entry;
            found_d     = 1'b1;
            carry_d     = ram_rdata_i;
          end
        end
        if (idx_q < count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = phys(head_q, idx_q);
          idx_d       = idx_q + CNT_W'(1);
          rd_pend_d   = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
        end
        if (!rd_pend_q && (idx_q == count_q)) begin
          ram_we_o                  = 1'b1;
          ram_waddr_o               = phys(head_q, count_q);
          ram_wdata_o               = found_q ? carry_q : new_entry;
          count_d                   = count_q + CNT_W'(1);
          evt_o.valid               = 1'b1;
          evt_o.res.status          = ST_ACCEPT;
          evt_o.res.task_handle_out = new_handle_q;
          evt_o.res.last            = 1'b1;
          state_d                   = S_IDLE;
        end
      end

      S_TICK_RD: begin
        if ((n_q < DISP_CNT_W'(MAX_RESULTS)) && (count_q != '0)) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = head_q;
          state_d     = S_TICK_EV;
        end else begin
          state_d = S_TICK_END;
        end
      end

      S_TICK_EV: begin
        if (!age[TIME_WIDTH-1]) begin
          // head is due: release the held item, hold this one
          if (pend_q) begin
            evt_o.valid               = 1'b1;
            evt_o.res.status          = ST_DISPATCH;
            evt_o.res.task_handle_out = pend_handle_q;
            evt_o.res.last            = 1'b0;
          end
          pend_d        = 1'b1;
          pend_handle_d = rd_handle;
          head_d        = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
          count_d       = count_q - CNT_W'(1);
          n_d           = n_q + DISP_CNT_W'(1);
          state_d       = S_TICK_RD;
        end else begin
          state_d = S_TICK_END;
        end
      end

      S_TICK_END: begin
        if (pend_q) begin
          evt_o.valid               = 1'b1;
          evt_o.res.status          = ST_DISPATCH;
          evt_o.res.task_handle_out = pend_handle_q;
          evt_o.res.last            = 1'b1;
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      count_q   <= '0;
      now_q     <= '0;
      stopped_q <= 1'b0;
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
      found_q   <= 1'b0;
      n_q       <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      now_q     <= now_d;
      stopped_q <= stopped_d;
      idx_q     <= idx_d;
      rd_pend_q <= rd_pend_d;
      found_q   <= found_d;
      n_q       <= n_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_due_q     <= new_due_d;
    new_handle_q  <= new_handle_d;
    carry_q       <= carry_d;
    pend_handle_q <= pend_handle_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[sv/delayed_task_queue_top.sv]
// ----------------------------------------------------------------------------
// delayed_task_queue_top
// Timer queue of task handles kept sorted by due time.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on a rising edge with start_i high and busy_o low.
//   A post item inserts its handle at now + delay_ms behind all entries due
//   no later, and answers with one result (accepted or refused when full).
//   A tick item advances the internal millisecond counter and dispatches the
//   due head entries, at most sixteen per tick; the final one carries last.
//   A stop item halts dispatch until reset.
//   Results appear on result_o for one cycle, marked by result_valid_o; the
//   receiver cannot stall them.
// Timing:
//   Post: busy while it reads each stored entry in turn, then makes the final
//   write; the result shows on the first cycle with busy low. Refused post:
//   result the cycle after the item, not busy.
//   Tick: each head entry is read from the RAM and then judged, until the
//   walk stops on an entry not yet due, an empty queue or the per-tick limit;
//   results pass through the output register, so they trail the walk.
//   Stop, an unused kind, or a tick while stopped: no busy time.
// Reset: empties the queue, clears time and the stop flag; the entry RAM
//   needs no clearing since only occupied entries are read.
// ----------------------------------------------------------------------------
module delayed_task_queue_top #(
  parameter int unsigned QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_WIDTH  = dtq_pkg::TIME_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  dtq_pkg::item_t   item_i,
  output logic             busy_o,
  output logic             result_valid_o,
  output dtq_pkg::result_t result_o
);

  import dtq_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned ENT_W = TIME_WIDTH + HANDLE_W;

  result_evt_t      evt;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  logic             result_valid_q;
  result_t          result_q;

  dtq_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .evt_o      (evt),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  dtq_ram #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output stage: each result shows for exactly one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= evt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= evt.res;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // a post answers with exactly one result, so it always closes its item
  a_post_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status != ST_DISPATCH)) |-> result_o.last)
    else $error("post result without last");

  // the walk never reads the slot it is writing in the same cycle
  a_ram_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write of the same entry in one cycle");

  // busy only starts on an accepted item
  a_busy_on_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without an item");

endmodule
